### src/morse_code_encoder_macros.svh
// ----------------------------------------------------------------------------
// Morse code encoder assertion macros
// Shorthand for the clocked concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_ENCODER_MACROS_SVH
`define MORSE_CODE_ENCODER_MACROS_SVH

// Assertion that is switched off while the synchronous reset is held.
`define MCE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is held.
`define MCE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/mce_pkg.sv
// ----------------------------------------------------------------------------
// Morse code encoder package
// Types, register map, segment length codes and the International Morse table.
// ----------------------------------------------------------------------------
`default_nettype none

package mce_pkg;

    localparam int CHAR_W = 8;
    localparam int UNIT_W = 16;
    localparam int DUR_W  = 19;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [UNIT_W-1:0] t_unit;
    typedef logic [DUR_W-1:0]  t_dur;

    // Register index, taken from the word address.
    localparam logic REG_UNIT_TICKS = 1'b0;

    localparam t_unit UNIT_TICKS_RST = 16'd200;

    // Segment length in units.
    typedef logic [1:0] t_mult;
    localparam t_mult MULT_1 = 2'd0;
    localparam t_mult MULT_3 = 2'd1;
    localparam t_mult MULT_7 = 2'd2;

    // One segment request from the sequencer to the duration unit.
    typedef struct packed {
        logic  light_on;
        t_mult mult;
        logic  last;
    } t_seg_req;

    // Decoded character. The pattern is left aligned: bit 4 is the first
    // element sent, and a set bit is a dash.
    typedef struct packed {
        logic       valid;
        logic       space;
        logic [2:0] len;
        logic [4:0] pat;
    } t_code;

    function automatic logic [7:0] letter_code(input logic [4:0] idx);
        logic [7:0] r;
        r = 8'h00;
        unique case (idx)
            5'd0:    r = {3'd2, 5'b01000};
            5'd1:    r = {3'd4, 5'b10000};
            5'd2:    r = {3'd4, 5'b10100};
            5'd3:    r = {3'd3, 5'b10000};
            5'd4:    r = {3'd1, 5'b00000};
            5'd5:    r = {3'd4, 5'b00100};
            5'd6:    r = {3'd3, 5'b11000};
            5'd7:    r = {3'd4, 5'b00000};
            5'd8:    r = {3'd2, 5'b00000};
            5'd9:    r = {3'd4, 5'b01110};
            5'd10:   r = {3'd3, 5'b10100};
            5'd11:   r = {3'd4, 5'b01000};
            5'd12:   r = {3'd2, 5'b11000};
            5'd13:   r = {3'd2, 5'b10000};
            5'd14:   r = {3'd3, 5'b11100};
            5'd15:   r = {3'd4, 5'b01100};
            5'd16:   r = {3'd4, 5'b11010};
            5'd17:   r = {3'd3, 5'b01000};
            5'd18:   r = {3'd3, 5'b00000};
            5'd19:   r = {3'd1, 5'b10000};
            5'd20:   r = {3'd3, 5'b00100};
            5'd21:   r = {3'd4, 5'b00010};
            5'd22:   r = {3'd3, 5'b01100};
            5'd23:   r = {3'd4, 5'b10010};
            5'd24:   r = {3'd4, 5'b10110};
            5'd25:   r = {3'd4, 5'b11000};
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] digit_pat(input logic [3:0] idx);
        logic [4:0] r;
        r = 5'b00000;
        unique case (idx)
            4'd0:    r = 5'b11111;
            4'd1:    r = 5'b01111;
            4'd2:    r = 5'b00111;
            4'd3:    r = 5'b00011;
            4'd4:    r = 5'b00001;
            4'd5:    r = 5'b00000;
            4'd6:    r = 5'b10000;
            4'd7:    r = 5'b11000;
            4'd8:    r = 5'b11100;
            4'd9:    r = 5'b11110;
            default: r = 5'b00000;
        endcase
        return r;
    endfunction

    function automatic t_code lookup(input t_char c);
        t_code      r;
        t_char      low;
        t_char      li;
        t_char      di;
        logic [7:0] lc;
        r   = '0;
        low = c | 8'h20;
        li  = low - 8'h61;
        di  = c - 8'h30;
        lc  = letter_code(li[4:0]);
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            r.space = 1'b1;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.valid = 1'b1;
            r.len   = 3'd5;
            r.pat   = digit_pat(di[3:0]);
        end else if (low >= 8'h61 && low <= 8'h7A) begin
            r.valid = 1'b1;
            r.len   = lc[7:5];
            r.pat   = lc[4:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/mce_if.sv
// ----------------------------------------------------------------------------
// Morse code encoder channel interfaces
// Valid/ready channels for input characters and output light segments.
// ----------------------------------------------------------------------------
`default_nettype none

interface mce_char_if;
    logic          valid;
    logic          ready;
    mce_pkg::t_char char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface mce_seg_if;
    logic          valid;
    logic          ready;
    logic          light_on;
    mce_pkg::t_dur duration_ticks;
    logic          last_segment;

    modport source (output valid, output light_on, output duration_ticks,
                    output last_segment, input ready);
    modport sink   (input valid, input light_on, input duration_ticks,
                    input last_segment, output ready);
endinterface

`default_nettype wire

### src/mce_dur.sv
// ----------------------------------------------------------------------------
// Morse segment duration unit
// Shared shift-and-add/subtract unit that forms unit_ticks times 1, 3 or 7.
// ----------------------------------------------------------------------------
`default_nettype none

module mce_dur (
    input  wire mce_pkg::t_unit i_unit,
    input  wire mce_pkg::t_mult i_mult,
    output mce_pkg::t_dur       o_dur
);
    import mce_pkg::*;

    t_dur base;
    t_dur u;
    logic sub;

    assign u = t_dur'(i_unit);

    // Three units is twice plus once, seven units is eight times minus once.
    always_comb begin
        base = '0;
        sub  = 1'b0;
        unique case (i_mult)
            MULT_1: base = '0;
            MULT_3: base = {u[DUR_W-2:0], 1'b0};
            MULT_7: begin
                base = {u[DUR_W-4:0], 3'b000};
                sub  = 1'b1;
            end
            default: base = '0;
        endcase
    end

    assign o_dur = sub ? (base - u) : (base + u);

endmodule

`default_nettype wire

### src/morse_code_encoder.sv
// Once a character is accepted, the sequencer enters its run state and then loads the
// first segment into the output registers. A letter or digit of n elements gives 2n
// segments, one per cycle while the sink takes them; the next character can be accepted
// in the cycle after the last segment is loaded. Ignored codes give no segments. The
// sequencer forms one segment length per unstalled cycle on the shared duration unit.
// Reset is synchronous: the sequencer goes idle, no segment is valid, unit_ticks is 200.
// ----------------------------------------------------------------------------
// Morse code encoder
// Turns ASCII characters into timed on/off light segments.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_code_encoder (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    mce_char_if.sink                     i_char,
    mce_seg_if.source                    o_seg,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [mce_pkg::APB_AW-1:0]    paddr,
    input  wire [mce_pkg::APB_DW-1:0]    pwdata,
    output logic [mce_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import mce_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic       r_state;
    t_unit      r_unit;
    logic       r_ws;
    logic [2:0] r_len_m1;
    logic [4:0] r_pat;
    logic [3:0] r_seg;

    logic       r_out_valid;
    logic       r_light_on;
    t_dur       r_dur;
    logic       r_last;

    t_code      code;
    t_seg_req   req;
    t_dur       dur;
    logic       accept;
    logic       advance;
    logic [2:0] elem;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_UNIT_TICKS) ? APB_DW'(r_unit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_TICKS_RST;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_UNIT_TICKS) begin
            r_unit <= pwdata[UNIT_W-1:0];
        end
    end

    assign i_char.ready = (r_state == S_IDLE);
    assign accept       = i_char.valid && i_char.ready;
    assign code         = lookup(i_char.char_code);
    assign advance      = (r_state == S_RUN) && (!r_out_valid || o_seg.ready);
    assign elem         = r_seg[3:1];

    // Even segments are elements, odd ones are the gaps after them; the gap after the
    // final element closes the character. Whitespace is one closing seven-unit gap.
    always_comb begin
        req = '0;
        if (r_ws) begin
            req.mult = MULT_7;
            req.last = 1'b1;
        end else if (!r_seg[0]) begin
            req.light_on = 1'b1;
            req.mult     = r_pat[3'd4 - elem] ? MULT_3 : MULT_1;
        end else if (elem == r_len_m1) begin
            req.mult = MULT_3;
            req.last = 1'b1;
        end else begin
            req.mult = MULT_1;
        end
    end

    mce_dur u_dur (
        .i_unit (r_unit),
        .i_mult (req.mult),
        .o_dur  (dur)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (code.valid || code.space)) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (advance && req.last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_seg.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ws     <= code.space;
            r_len_m1 <= code.len - 3'd1;
            r_pat    <= code.pat;
            r_seg    <= '0;
        end else if (advance) begin
            r_seg    <= r_seg + 4'd1;
        end
        if (advance) begin
            r_light_on <= req.light_on;
            r_dur      <= dur;
            r_last     <= req.last;
        end
    end

    assign o_seg.valid          = r_out_valid;
    assign o_seg.light_on       = r_light_on;
    assign o_seg.duration_ticks = r_dur;
    assign o_seg.last_segment   = r_last;

endmodule

`default_nettype wire

### src/mce_chk.sv
// ----------------------------------------------------------------------------
// Morse code encoder checker
// Port-level assertions on the segment channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "morse_code_encoder_macros.svh"

module mce_chk (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire                i_light_on,
    input wire mce_pkg::t_dur i_duration,
    input wire                i_last
);
    import mce_pkg::*;

    // A waiting segment is neither dropped nor altered.
    `MCE_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "segment dropped while stalled")
    `MCE_ASSERT(a_stall_data, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_duration) && $stable(i_light_on) && $stable(i_last), "segment changed while stalled")

    // Every character closes with the light off.
    `MCE_ASSERT(a_last_off, i_clk, i_rst_n, i_out_valid && i_last |-> !i_light_on, "final segment has the light on")

    `MCE_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "segment valid after reset")

endmodule

bind morse_code_encoder mce_chk u_mce_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_seg.valid),
    .i_out_ready (o_seg.ready),
    .i_light_on  (o_seg.light_on),
    .i_duration  (o_seg.duration_ticks),
    .i_last      (o_seg.last_segment)
);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Morse code encoder testbench
// Drives ASCII characters into the encoder, predicts the light segments each
// one should produce from the International Morse table and the current unit
// length, and checks every segment transaction in order. Covers the unit
// register extremes, whitespace and ignored codes, and random traffic under
// varying back-pressure on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import mce_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_UNIT_TICKS = APB_AW'(4 * int'(REG_UNIT_TICKS));
    localparam int SETTLE_CYCLES = 16;
    localparam int RUN_LIMIT     = 400000;

    typedef struct packed {
        logic light_on;
        t_dur duration;
        logic last;
    } t_light_seg;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    mce_char_if char_ch ();
    mce_seg_if  seg_ch ();

    morse_code_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_seg   (seg_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    string letter_morse [26] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
    };
    string digit_morse [10] = '{
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    t_light_seg pending_segs [$];
    t_unit      unit_setting;
    int         src_idle_pct;
    int         snk_idle_pct;
    int         mismatch_count;
    int         chars_sent;
    int         segs_checked;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Work out the segments one character should produce and queue them.
    function automatic void predict_segments(input t_char c);
        string pat;
        t_dur  one_unit;
        t_dur  three_units;
        t_dur  seven_units;
        one_unit    = {3'b000, unit_setting};
        three_units = {3'b000, unit_setting} * 19'd3;
        seven_units = {3'b000, unit_setting} * 19'd7;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            pending_segs.push_back('{1'b0, seven_units, 1'b1});
            return;
        end
        if (c >= "0" && c <= "9") begin
            pat = digit_morse[c - "0"];
        end else if (c >= "a" && c <= "z") begin
            pat = letter_morse[c - "a"];
        end else if (c >= "A" && c <= "Z") begin
            pat = letter_morse[c - "A"];
        end else begin
            return;
        end
        for (int i = 0; i < pat.len(); i++) begin
            if (i > 0) begin
                pending_segs.push_back('{1'b0, one_unit, 1'b0});
            end
            pending_segs.push_back('{1'b1, (pat[i] == "-") ? three_units : one_unit, 1'b0});
        end
        pending_segs.push_back('{1'b0, three_units, 1'b1});
    endfunction

    task automatic send_char(input t_char c);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            char_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        predict_segments(c);
        chars_sent++;
    endtask

    // Stop sending and wait for the encoder to go quiet.
    task automatic drain;
        @(negedge i_clk);
        char_ch.valid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_read_check(input t_unit want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_UNIT_TICKS;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[UNIT_W-1:0] !== want) begin
            report_mismatch($sformatf("unit_ticks read %0d, expected %0d",
                                      prdata[UNIT_W-1:0], want));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_unit(input t_unit v);
        drain();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_UNIT_TICKS;
        pwdata  <= APB_DW'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        unit_setting = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apb_read_check(v);
    endtask

    // Mostly letters and digits, with some whitespace and arbitrary codes.
    function automatic t_char pick_char;
        int r;
        t_char ws_codes [6] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
        r = $urandom_range(99);
        if (r < 45) begin
            return t_char'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
        end else if (r < 75) begin
            return t_char'("0" + $urandom_range(9));
        end else if (r < 85) begin
            return ws_codes[$urandom_range(5)];
        end
        return t_char'($urandom_range(255));
    endfunction

    task automatic test_reset_value;
        apb_read_check(UNIT_TICKS_RST);
    endtask

    task automatic test_directed_chars;
        t_char cases [25] = '{
            "E", "T", "0", "9", "5", "a", "z", "Z", "Q",
            8'h09, 8'h0A, 8'h0D, 8'h20,
            8'h00, 8'h08, 8'h0E, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B,
            8'h7F, 8'h80, 8'hFF
        };
        foreach (cases[i]) send_char(cases[i]);
    endtask

    // A zero unit lies outside the documented range but must still give
    // the usual segment pattern with zero durations.
    task automatic test_unit_extremes;
        t_unit units [3] = '{16'd1, 16'hFFFF, 16'd0};
        t_char chars [5] = '{"0", "h", " ", "?", "j"};
        foreach (units[u]) begin
            write_unit(units[u]);
            foreach (chars[i]) send_char(chars[i]);
        end
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input t_unit unit, input int count);
        write_unit(unit);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (count) send_char(pick_char());
    endtask

    // The receiver stalls at random; the rate changes between phases.
    always @(negedge i_clk) begin
        seg_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        t_light_seg got;
        t_light_seg want;
        if (i_rst_n && seg_ch.valid && seg_ch.ready) begin
            got = '{seg_ch.light_on, seg_ch.duration_ticks, seg_ch.last_segment};
            if (pending_segs.size() == 0) begin
                report_mismatch($sformatf("unexpected segment on=%0b dur=%0d last=%0b",
                                          got.light_on, got.duration, got.last));
            end else begin
                want = pending_segs.pop_front();
                segs_checked++;
                if (got.light_on !== want.light_on) begin
                    report_mismatch($sformatf("light_on %0b, expected %0b",
                                              got.light_on, want.light_on));
                end
                if (got.duration !== want.duration) begin
                    report_mismatch($sformatf("duration_ticks %0d, expected %0d",
                                              got.duration, want.duration));
                end
                if (got.last !== want.last) begin
                    report_mismatch($sformatf("last_segment %0b, expected %0b",
                                              got.last, want.last));
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("morse_code_encoder verification failed");
        $finish;
    end

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        unit_setting      = UNIT_TICKS_RST;
        src_idle_pct      = 29;
        snk_idle_pct      = 82;
        mismatch_count    = 0;
        chars_sent        = 0;
        segs_checked      = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_value();
        test_directed_chars();
        test_unit_extremes();
        test_random_traffic(29, 82, t_unit'($urandom_range(1, 65535)), 27);
        test_random_traffic(82, 29, t_unit'($urandom_range(1, 8)), 27);
        test_random_traffic(0, 0, t_unit'($urandom_range(1, 65535)), 27);
        drain();

        $display("Sent %0d characters and checked %0d segments, with unit lengths",
                 chars_sent, segs_checked);
        $display("of 0, 1, 200, 65535 and random values under changing back-pressure.");
        if (mismatch_count == 0) begin
            $display("morse_code_encoder verification clean");
        end else begin
            $display("morse_code_encoder verification failed");
        end
        $finish;
    end

endmodule

### morse_code_encoder.f
+incdir+src
src/mce_pkg.sv
src/mce_if.sv
src/mce_dur.sv
src/morse_code_encoder.sv
src/mce_chk.sv
tb/testbench.sv
